// File: rtl/tcp_ipv4_checksum_offload_core_defines.svh
// Assertion macros for the TCP/IPv4 checksum offload core.
// Included by the RTL files that carry concurrent assertions; no other dependencies.
`ifndef TCP_IPV4_CHECKSUM_OFFLOAD_CORE_DEFINES_SVH
`define TCP_IPV4_CHECKSUM_OFFLOAD_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define CSO_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("checksum core assertion failed");
// next-cycle implication
`define CSO_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("checksum core assertion failed");
`else
`define CSO_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define CSO_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: rtl/tcpcso_pkg.sv
// Shared types, register codes, header constants and the checksum fold helper
// for the TCP/IPv4 checksum offload core. No dependencies.
package tcpcso_pkg;

  // input item: one payload byte with its qualifiers
  typedef struct packed {
    logic [7:0] payload_byte;
    logic       byte_valid;
    logic       last;
  } in_item_t;

  // result item: checksums and length of one segment
  typedef struct packed {
    logic [15:0] ip_checksum;
    logic [15:0] tcp_checksum;
    logic [15:0] total_length;
    logic        length_error;
  } out_item_t;

  localparam int CFG_DATA_W = 32;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_SOURCE_ADDRESS = 2'd0,
    CFG_DEST_ADDRESS   = 2'd1,
    CFG_SOURCE_PORT    = 2'd2,
    CFG_DEST_PORT      = 2'd3
  } cfg_index_t;

  // IPv4 fixed words: 0x4500, id 111, ttl 111 with protocol 6
  localparam logic [15:0] IP_HDR_CONST  = 16'hB475;
  // TCP fixed words: seq 111, ack 111, offset/SYN 0x5002, window 100,
  // plus the pseudo-header protocol word 6
  localparam logic [15:0] TCP_HDR_CONST = 16'h514A;

  localparam logic [16:0] COUNT_MAX   = 17'h1FFFF;
  localparam logic [16:0] MAX_PAYLOAD = 17'd65495;
  localparam logic [15:0] HDR_LEN     = 16'd40;
  localparam logic [15:0] TCP_HDR_LEN = 16'd20;
  localparam logic [15:0] TOTAL_SAT   = 16'hFFFF;
  localparam logic [15:0] SEG_SAT     = 16'd65515;

  // Fold a nonzero sum of up to eight 16-bit words with end-around carry.
  function automatic logic [15:0] fold19(input logic [18:0] x);
    logic [16:0] f;
    f = {1'b0, x[15:0]} + {14'b0, x[18:16]};
    return f[15:0] + {15'b0, f[16]};
  endfunction

endpackage

// File: rtl/tcp_ipv4_checksum_offload_core.sv
// TCP/IPv4 checksum offload core: folds payload bytes, emits IP/TCP checksums.
// Depends on tcpcso_pkg and tcp_ipv4_checksum_offload_core_defines.svh.
// A last item's result is built from the input register into out_data_r.
// Throughput: one item per cycle; the input register only stalls when it holds
// a last item and the result register is still waiting to be taken.
// Reset (rst_n low, synchronous) clears config, accumulator and valid flags.
`include "tcp_ipv4_checksum_offload_core_defines.svh"

module tcp_ipv4_checksum_offload_core
  import tcpcso_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  cfg_index_t            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data
);

  logic [31:0] src_addr_r, dst_addr_r;
  logic [15:0] src_port_r, dst_port_r;
  logic [15:0] cfg_ip_r, cfg_tcp_r;
  logic [15:0] cfg_ip_nxt, cfg_tcp_nxt;

  logic        s1_valid_r, s1_valid_nxt;
  in_item_t    s1_data_r;
  logic        s1_adv, out_free;

  logic [15:0] run_r, run_nxt;
  logic [16:0] count_r, count_nxt;
  logic [7:0]  hold_r, hold_nxt;
  logic        odd_r, odd_nxt;

  logic        out_valid_r, out_valid_nxt;
  out_item_t   out_data_r, out_data_nxt;

  logic [16:0] pair_sum, cnt_inc, cnt_now;
  logic [15:0] extra_w, total_len, seg_len, ip_sum, tcp_sum;
  logic        len_err;

  // write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_addr_r <= '0;
      dst_addr_r <= '0;
      src_port_r <= '0;
      dst_port_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SOURCE_ADDRESS: src_addr_r <= cfg_wdata;
        CFG_DEST_ADDRESS:   dst_addr_r <= cfg_wdata;
        CFG_SOURCE_PORT:    src_port_r <= cfg_wdata[15:0];
        CFG_DEST_PORT:      dst_port_r <= cfg_wdata[15:0];
      endcase
    end
  end

  // precompute the header sums that depend only on configuration
  always_comb begin
    cfg_ip_nxt  = fold19({3'b0, IP_HDR_CONST}
                         + {3'b0, src_addr_r[31:16]} + {3'b0, src_addr_r[15:0]}
                         + {3'b0, dst_addr_r[31:16]} + {3'b0, dst_addr_r[15:0]});
    cfg_tcp_nxt = fold19({3'b0, TCP_HDR_CONST}
                         + {3'b0, src_addr_r[31:16]} + {3'b0, src_addr_r[15:0]}
                         + {3'b0, dst_addr_r[31:16]} + {3'b0, dst_addr_r[15:0]}
                         + {3'b0, src_port_r} + {3'b0, dst_port_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_ip_r  <= IP_HDR_CONST;
      cfg_tcp_r <= TCP_HDR_CONST;
    end else begin
      cfg_ip_r  <= cfg_ip_nxt;
      cfg_tcp_r <= cfg_tcp_nxt;
    end
  end

  // handshake: only a last item waits on the result register
  assign out_free = !out_valid_r || out_ready;
  assign s1_adv   = s1_valid_r && (!s1_data_r.last || out_free);
  assign in_ready = !s1_valid_r || s1_adv;

  // accumulate payload and build the result
  always_comb begin
    run_nxt       = run_r;
    count_nxt     = count_r;
    hold_nxt      = hold_r;
    odd_nxt       = odd_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;

    pair_sum = {1'b0, run_r} + {1'b0, hold_r, s1_data_r.payload_byte};
    cnt_inc  = (count_r != COUNT_MAX) ? count_r + 17'd1 : count_r;
    cnt_now  = s1_data_r.byte_valid ? cnt_inc : count_r;

    // word still pending at the end of the payload, padded low byte
    case ({s1_data_r.byte_valid, odd_r})
      2'b11:   extra_w = {hold_r, s1_data_r.payload_byte};
      2'b10:   extra_w = {s1_data_r.payload_byte, 8'h00};
      2'b01:   extra_w = {hold_r, 8'h00};
      default: extra_w = 16'h0000;
    endcase

    len_err   = cnt_now > MAX_PAYLOAD;
    total_len = len_err ? TOTAL_SAT : HDR_LEN + cnt_now[15:0];
    seg_len   = len_err ? SEG_SAT : TCP_HDR_LEN + cnt_now[15:0];
    ip_sum    = fold19({3'b0, cfg_ip_r} + {3'b0, total_len});
    tcp_sum   = fold19({3'b0, run_r} + {3'b0, extra_w}
                       + {3'b0, cfg_tcp_r} + {3'b0, seg_len});

    if (s1_adv) begin
      if (s1_data_r.last) begin
        out_valid_nxt             = 1'b1;
        out_data_nxt.ip_checksum  = ~ip_sum;
        out_data_nxt.tcp_checksum = ~tcp_sum;
        out_data_nxt.total_length = total_len;
        out_data_nxt.length_error = len_err;
        run_nxt   = '0;
        count_nxt = '0;
        hold_nxt  = '0;
        odd_nxt   = 1'b0;
      end else if (s1_data_r.byte_valid) begin
        count_nxt = cnt_inc;
        if (!odd_r) begin
          hold_nxt = s1_data_r.payload_byte;
          odd_nxt  = 1'b1;
        end else begin
          run_nxt = pair_sum[15:0] + {15'b0, pair_sum[16]};
          odd_nxt = 1'b0;
        end
      end
    end

    s1_valid_nxt = (in_valid && in_ready) || (s1_valid_r && !s1_adv);
  end

  // control and accumulator state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      run_r       <= '0;
      count_r     <= '0;
      hold_r      <= '0;
      odd_r       <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      run_r       <= run_nxt;
      count_r     <= count_nxt;
      hold_r      <= hold_nxt;
      odd_r       <= odd_nxt;
    end
  end

  // payload registers: capture input on transfer, result when built
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_data_r <= in_data;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // a non-last item never leaves a result behind
  `CSO_ASSERT_NEXT(a_no_result_without_last, clk, rst_n,
                   s1_valid_r && !s1_data_r.last && out_free, !out_valid_r)
  // accumulator is cleared after a segment closes
  `CSO_ASSERT_NEXT(a_clear_after_last, clk, rst_n, s1_adv && s1_data_r.last,
                   run_r == 16'h0000 && count_r == 17'h00000 && !odd_r)
  // input stalls only behind a waiting result
  `CSO_ASSERT_IMPL(a_stall_cause, clk, rst_n, !in_ready,
                   s1_valid_r && s1_data_r.last && out_valid_r && !out_ready)
  // oversized payload reports a saturated length
  `CSO_ASSERT_IMPL(a_len_error_sat, clk, rst_n, out_valid_r && out_data_r.length_error,
                   out_data_r.total_length == TOTAL_SAT)

endmodule

// File: test/tcp_ipv4_checksum_offload_core_tb.sv
// Self-checking testbench for the TCP/IPv4 checksum offload core.
// Depends on tcpcso_pkg; predicts checksums and lengths per segment and
// compares them with every result transfer.
module tcp_ipv4_checksum_offload_core_tb;
  import tcpcso_pkg::*;

  localparam int          WATCHDOG_LIMIT = 5000;
  localparam int          LONG_HOLD      = 300;
  localparam int          DRAIN_CYCLES   = 8;
  localparam int          RANDOM_ITEMS   = 1800;
  localparam logic [16:0] BYTE_CNT_SAT   = 17'h1FFFF;
  localparam logic [16:0] PAYLOAD_LIMIT  = 17'd65495;
  // fixed header words of the SYN segment
  localparam logic [15:0] IP_VER_IHL_TOS = 16'h4500;
  localparam logic [15:0] IP_IDENT       = 16'd111;
  localparam logic [15:0] IP_TTL_PROTO   = {8'd111, 8'd6};
  localparam logic [15:0] TCP_SEQ_LO     = 16'd111;
  localparam logic [15:0] TCP_ACK_LO     = 16'd111;
  localparam logic [15:0] TCP_OFF_FLAGS  = 16'h5002;
  localparam logic [15:0] TCP_WINDOW     = 16'd100;
  localparam logic [15:0] PROTO_TCP      = 16'd6;
  localparam logic [15:0] TCP_HDR_BYTES  = 16'd20;
  localparam logic [15:0] ALL_HDR_BYTES  = 16'd40;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  cfg_index_t            cfg_index = CFG_SOURCE_ADDRESS;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_item_t              in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_data;

  tcp_ipv4_checksum_offload_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #4 clk = ~clk;

  // register shadow
  logic [31:0] src_ip = '0;
  logic [31:0] dst_ip = '0;
  logic [15:0] src_port = '0;
  logic [15:0] dst_port = '0;

  // payload accumulator shadow
  logic [15:0] sum_acc;
  logic [16:0] byte_cnt;
  logic [7:0]  hi_byte;
  logic        odd_byte;

  in_item_t  tx_items[$];
  out_item_t pending_results[$];
  out_item_t want;

  int  errors = 0;
  int  segments_checked = 0;
  int  oversize_seen = 0;
  int  bytes_moved = 0;
  int  counted_items = 0;
  int  settings_used = 1;
  int  send_gap = 0;
  int  rx_stall = 0;
  int  idle_cycles = 0;
  bit  quiet = 1'b0;
  bit  hold_done = 1'b0;

  function automatic logic [15:0] oc_add(logic [15:0] a, logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'b0, s[16]};
  endfunction

  function automatic logic [15:0] addr_sum(logic [15:0] acc);
    acc = oc_add(acc, src_ip[31:16]);
    acc = oc_add(acc, src_ip[15:0]);
    acc = oc_add(acc, dst_ip[31:16]);
    return oc_add(acc, dst_ip[15:0]);
  endfunction

  function automatic logic [15:0] ip_header_sum(logic [15:0] total);
    logic [15:0] s;
    s = oc_add(IP_VER_IHL_TOS, total);
    s = oc_add(s, IP_IDENT);
    s = oc_add(s, IP_TTL_PROTO);
    return addr_sum(s);
  endfunction

  // TCP header plus pseudo-header, everything except the payload
  function automatic logic [15:0] tcp_header_sum(logic [15:0] seg_len);
    logic [15:0] s;
    s = oc_add(src_port, dst_port);
    s = oc_add(s, TCP_SEQ_LO);
    s = oc_add(s, TCP_ACK_LO);
    s = oc_add(s, TCP_OFF_FLAGS);
    s = oc_add(s, TCP_WINDOW);
    s = addr_sum(s);
    s = oc_add(s, PROTO_TCP);
    return oc_add(s, seg_len);
  endfunction

  // Fold one accepted item; on last, queue the expected segment result.
  task automatic absorb_item(in_item_t it);
    logic [15:0] tsum;
    logic [15:0] total;
    logic        err;
    out_item_t   r;
    if (it.byte_valid) begin
      if (!odd_byte) begin
        hi_byte  = it.payload_byte;
        odd_byte = 1'b1;
      end else begin
        sum_acc  = oc_add(sum_acc, {hi_byte, it.payload_byte});
        odd_byte = 1'b0;
      end
      if (byte_cnt != BYTE_CNT_SAT) byte_cnt = byte_cnt + 17'd1;
      bytes_moved++;
    end
    if (it.last) begin
      tsum = sum_acc;
      if (odd_byte) tsum = oc_add(tsum, {hi_byte, 8'h00});
      err   = byte_cnt > PAYLOAD_LIMIT;
      total = err ? 16'hFFFF : byte_cnt[15:0] + ALL_HDR_BYTES;
      tsum  = oc_add(tsum, tcp_header_sum(total - TCP_HDR_BYTES));
      r.ip_checksum  = ~ip_header_sum(total);
      r.tcp_checksum = ~tsum;
      r.total_length = total;
      r.length_error = err;
      pending_results.push_back(r);
      sum_acc  = '0;
      byte_cnt = '0;
      hi_byte  = '0;
      odd_byte = 1'b0;
    end
  endtask

  // Shadow register writes as the core sees them
  always @(posedge clk) begin
    if (cfg_we) begin
      case (cfg_index)
        CFG_SOURCE_ADDRESS: src_ip   <= cfg_wdata;
        CFG_DEST_ADDRESS:   dst_ip   <= cfg_wdata;
        CFG_SOURCE_PORT:    src_port <= cfg_wdata[15:0];
        CFG_DEST_PORT:      dst_port <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // Driver: predict on each input transfer, then offer the next item or idle
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      sum_acc  = '0;
      byte_cnt = '0;
      hi_byte  = '0;
      odd_byte = 1'b0;
    end else begin
      if (in_valid && in_ready) absorb_item(in_data);
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (tx_items.size() > 0) begin
          in_data  <= tx_items.pop_front();
          in_valid <= 1'b1;
          if (!quiet && $urandom_range(0, 9) == 0) send_gap = $urandom_range(1, 8);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result transfer, then decide the next ready
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result %h", $time, out_data);
          errors++;
        end else begin
          want = pending_results.pop_front();
          segments_checked++;
          if (out_data.length_error) oversize_seen++;
          if (out_data.ip_checksum !== want.ip_checksum) begin
            $display("%0t: ip_checksum expected %h got %h", $time,
                     want.ip_checksum, out_data.ip_checksum);
            errors++;
          end
          if (out_data.tcp_checksum !== want.tcp_checksum) begin
            $display("%0t: tcp_checksum expected %h got %h", $time,
                     want.tcp_checksum, out_data.tcp_checksum);
            errors++;
          end
          if (out_data.total_length !== want.total_length) begin
            $display("%0t: total_length expected %0d got %0d", $time,
                     want.total_length, out_data.total_length);
            errors++;
          end
          if (out_data.length_error !== want.length_error) begin
            $display("%0t: length_error expected %b got %b", $time,
                     want.length_error, out_data.length_error);
            errors++;
          end
        end
      end
      // hold off once for a long stretch so the core backs up into its input
      if (!hold_done && segments_checked >= 60) begin
        hold_done = 1'b1;
        rx_stall  = LONG_HOLD;
      end
      if (rx_stall > 0) begin
        rx_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (!quiet && $urandom_range(0, 5) == 0) rx_stall = $urandom_range(1, 8);
      end
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
      $display("FAIL tcp_ipv4_checksum_offload_core");
      $finish;
    end
  end

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 4))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h8000_0000;
      default: return $urandom();
    endcase
  endfunction

  task automatic push_item(logic [7:0] b, logic v, logic l);
    in_item_t it;
    it.payload_byte = b;
    it.byte_valid   = v;
    it.last         = l;
    tx_items.push_back(it);
    if (v || l) counted_items++;
  endtask

  // Queue one payload; end it on a valid byte or on an empty last item
  task automatic push_payload(int len, bit tail_valid, bit noisy);
    for (int i = 0; i < len; i++) begin
      if (noisy && $urandom_range(0, 9) == 0) push_item(pick_byte(), 1'b0, 1'b0);
      push_item(pick_byte(), 1'b1, tail_valid && (i == len - 1));
    end
    if (!tail_valid) push_item(pick_byte(), 1'b0, 1'b1);
  endtask

  // Wait until the core has nothing left in flight
  task automatic wait_drained();
    do @(negedge clk);
    while (tx_items.size() != 0 || in_valid || pending_results.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(logic [31:0] sa, logic [31:0] da, logic [15:0] sp,
                            logic [15:0] dp);
    wait_drained();
    @(posedge clk);
    cfg_we <= 1'b1; cfg_index <= CFG_SOURCE_ADDRESS; cfg_wdata <= sa;
    @(posedge clk);
    cfg_index <= CFG_DEST_ADDRESS; cfg_wdata <= da;
    @(posedge clk);
    cfg_index <= CFG_SOURCE_PORT; cfg_wdata <= {16'h0, sp};
    @(posedge clk);
    cfg_index <= CFG_DEST_PORT; cfg_wdata <= {16'h0, dp};
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    settings_used++;
  endtask

  task automatic random_traffic(int n_items);
    int start;
    int len;
    int r;
    start = counted_items;
    while (counted_items - start < n_items) begin
      r = $urandom_range(0, 15);
      if (r < 12)      len = $urandom_range(0, 12);
      else if (r < 15) len = $urandom_range(13, 64);
      else             len = $urandom_range(65, 300);
      push_payload(len, (len > 0) && $urandom_range(0, 1), 1'b1);
    end
  endtask

  initial begin
    logic [15:0] hdr;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed segments on reset register values
    push_item(8'h00, 1'b0, 1'b1);                       // empty payload
    push_item(8'hA5, 1'b0, 1'b0);                       // ignored, no last
    push_item(8'hFF, 1'b1, 1'b1);                       // single odd byte
    push_item(8'h00, 1'b1, 1'b0);
    push_item(8'hFF, 1'b1, 1'b1);
    push_item(8'hFF, 1'b1, 1'b0);
    push_item(8'hFF, 1'b1, 1'b0);
    push_item(8'h80, 1'b1, 1'b0);
    push_item(8'h3C, 1'b0, 1'b1);                       // last without its byte
    push_item(8'hAA, 1'b1, 1'b0);
    push_item(8'h55, 1'b1, 1'b0);
    push_item(8'hFF, 1'b1, 1'b0);
    push_item(8'h00, 1'b1, 1'b1);
    // two payload bytes that cancel the header sum: TCP checksum of zero
    hdr = ~tcp_header_sum(16'd22);
    push_item(hdr[15:8], 1'b1, 1'b0);
    push_item(hdr[7:0], 1'b1, 1'b1);

    set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
    push_item(8'h00, 1'b0, 1'b1);
    push_item(8'h01, 1'b1, 1'b0);
    push_item(8'h80, 1'b1, 1'b1);
    random_traffic(RANDOM_ITEMS / 6);

    for (int p = 0; p < 5; p++) begin
      set_config(pick_word(), pick_word(), 16'(pick_word()), 16'(pick_word()));
      random_traffic(RANDOM_ITEMS / 6);
    end

    // last part: no idling, payloads back to back
    set_config($urandom(), $urandom(), 16'($urandom()), 16'($urandom()));
    quiet = 1'b1;
    push_payload(3, 1'b1, 1'b0);
    random_traffic(100);

    wait_drained();
    repeat (16) @(posedge clk);
    if (pending_results.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, pending_results.size());
      errors++;
    end
    $display("Checked %0d segments (%0d over the length limit), %0d payload bytes,",
             segments_checked, oversize_seen, bytes_moved);
    $display("under %0d register settings with random stalls on both sides.",
             settings_used);
    if (errors == 0) begin
      $display("PASS tcp_ipv4_checksum_offload_core");
    end else begin
      $display("FAIL tcp_ipv4_checksum_offload_core");
    end
    $finish;
  end

endmodule
